// File: design/csv_decimal_field_parser_top_defines.svh
// ----------------------------------------------------------------------------
// CSV decimal field parser: assertion macros
// Shared concurrent assertion shorthands, one clock and one synchronous reset.
// ----------------------------------------------------------------------------
`ifndef CSV_DECIMAL_FIELD_PARSER_TOP_DEFINES_SVH
`define CSV_DECIMAL_FIELD_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cdfp_pkg.sv
// ----------------------------------------------------------------------------
// cdfp_pkg
// Shared types, character codes, defaults and the byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cdfp_pkg;

   // Default configuration
   localparam int INT_BITS_DEF    = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int MAX_ROWS_DEF    = 65536;

   // Port widths
   localparam int BYTE_W   = 8;
   localparam int VALUE_W  = 48;
   localparam int COLUMN_W = 10;
   localparam int ROW_W    = 16;
   localparam int DIGIT_W  = 4;
   localparam int FCNT_W   = 3;

   // Fraction digits beyond this count add nothing
   localparam logic [FCNT_W-1:0] FRAC_DIGITS_MAX = 3'd7;

   // Character codes
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CH_POINT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

   // Parse phase, one-hot
   typedef enum logic [2:0] {
      PH_INT  = 3'b001,
      PH_FRAC = 3'b010,
      PH_SKIP = 3'b100
   } cdfp_phase_type;

   // Decoded byte class
   typedef struct packed {
      logic               digit;
      logic [DIGIT_W-1:0] digit_val;
      logic               point;
      logic               sep;
      logic               newline;
   } cdfp_dec_type;

   // Per-cycle control from the input stage to the units
   typedef struct packed {
      logic step;     // byte in the input register is consumed this cycle
      logic sep;      // it is a separator
      logic newline;  // it is a newline
   } cdfp_ctl_type;

   function automatic cdfp_dec_type cdfp_decode(input logic [BYTE_W-1:0] ch);
      cdfp_dec_type       dec;
      logic [BYTE_W-1:0]  offs;
      offs          = ch - CH_ZERO;
      dec.digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);
      dec.digit_val = dec.digit ? offs[DIGIT_W-1:0] : '0;
      dec.point     = (ch == CH_POINT);
      dec.newline   = (ch == CH_NEWLINE);
      dec.sep       = (ch == CH_COMMA) || dec.newline;
      return dec;
   endfunction

endpackage

`default_nettype wire

// File: design/cdfp_field_acc.sv
// ----------------------------------------------------------------------------
// cdfp_field_acc
// Per-field number accumulator: integer digits, fraction digits, skip phase.
// ----------------------------------------------------------------------------
`default_nettype none
`include "csv_decimal_field_parser_top_defines.svh"

module cdfp_field_acc #(
   parameter int INT_BITS  = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cdfp_pkg::cdfp_ctl_type         ctl,
   input  wire cdfp_pkg::cdfp_dec_type         dec,
   output logic [cdfp_pkg::VALUE_W-1:0]        field_value,
   output logic                                overflow
);
   import cdfp_pkg::*;

   localparam int IW = INT_BITS + DIGIT_W;
   localparam int FW = FRAC_BITS + DIGIT_W;

   // Rounded weights of fraction digits one to seven
   localparam logic [FRAC_BITS-1:0] WEIGHT [0:6] = '{
      FRAC_BITS'(((2 ** FRAC_BITS) + 5) / 10),
      FRAC_BITS'(((2 ** FRAC_BITS) + 50) / 100),
      FRAC_BITS'(((2 ** FRAC_BITS) + 500) / 1000),
      FRAC_BITS'(((2 ** FRAC_BITS) + 5000) / 10000),
      FRAC_BITS'(((2 ** FRAC_BITS) + 50000) / 100000),
      FRAC_BITS'(((2 ** FRAC_BITS) + 500000) / 1000000),
      FRAC_BITS'(((2 ** FRAC_BITS) + 5000000) / 10000000)
   };

   cdfp_phase_type        phase_ff, phase_in;
   logic [INT_BITS-1:0]   int_ff, int_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [FCNT_W-1:0]     fcnt_ff, fcnt_in;
   logic                  ovf_ff, ovf_in;

   logic [IW-1:0]         int_ext;
   logic [IW-1:0]         int_next;
   logic [FRAC_BITS-1:0]  weight;
   logic [FW-1:0]         frac_next;
   logic [INT_BITS+FRAC_BITS-1:0] value_full;

   // Times ten plus digit, as two shifts and adds
   assign int_ext  = IW'(int_ff);
   assign int_next = (int_ext << 3) + (int_ext << 1) + IW'(dec.digit_val);

   // Weighted fraction digit
   assign weight    = (fcnt_ff == FRAC_DIGITS_MAX) ? '0 : WEIGHT[fcnt_ff];
   assign frac_next = FW'(frac_ff) + (FW'(dec.digit_val) * FW'(weight));

   // Next state
   always_comb begin
      phase_in = phase_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      fcnt_in  = fcnt_ff;
      ovf_in   = ovf_ff;
      if (ctl.step) begin
         if (ctl.sep) begin
            phase_in = PH_INT;
            int_in   = '0;
            frac_in  = '0;
            fcnt_in  = '0;
            ovf_in   = 1'b0;
         end else begin
            case (phase_ff)
               PH_INT: begin
                  if (dec.digit) begin
                     if (int_next[IW-1:INT_BITS] != '0) begin
                        int_in = '1;
                        ovf_in = 1'b1;
                     end else begin
                        int_in = int_next[INT_BITS-1:0];
                     end
                  end else if (dec.point) begin
                     phase_in = PH_FRAC;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_FRAC: begin
                  if (dec.digit) begin
                     if (fcnt_ff != FRAC_DIGITS_MAX) begin
                        frac_in = (frac_next[FW-1:FRAC_BITS] != '0) ? '1
                                  : frac_next[FRAC_BITS-1:0];
                        fcnt_in = fcnt_ff + 1'b1;
                     end
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INT;
         int_ff   <= '0;
         frac_ff  <= '0;
         fcnt_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         fcnt_ff  <= fcnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Fraction is below one, so the fixed-point sum is a concatenation
   assign value_full  = {int_ff, frac_ff};
   assign field_value = VALUE_W'(value_full);
   assign overflow    = ovf_ff;

   `CDFP_ASSERT_NEXT(a_sep_clears, clock, reset, ctl.step && ctl.sep,
      (phase_ff == PH_INT) && (int_ff == '0) && (frac_ff == '0) && !ovf_ff,
      "field state not cleared after separator")
   `CDFP_ASSERT_NOW(a_ovf_sat, clock, reset, ovf_ff, int_ff == '1,
      "overflow flag set without saturated integer part")

endmodule

`default_nettype wire

// File: design/cdfp_pos_count.sv
// ----------------------------------------------------------------------------
// cdfp_pos_count
// Column and row counters, both saturating at their limits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "csv_decimal_field_parser_top_defines.svh"

module cdfp_pos_count #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 65536
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cdfp_pkg::cdfp_ctl_type      ctl,
   output logic [cdfp_pkg::COLUMN_W-1:0]    column_index,
   output logic [cdfp_pkg::ROW_W-1:0]       row_index
);
   import cdfp_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Advance on each separator
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctl.step && ctl.sep) begin
         if (ctl.newline) begin
            col_in = '0;
            if (row_ff < ROW_LAST) begin
               row_in = row_ff + 1'b1;
            end
         end else if (col_ff < COL_LAST) begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign column_index = COLUMN_W'(col_ff);
   assign row_index    = ROW_W'(row_ff);

   `CDFP_ASSERT_NEXT(a_nl_col_zero, clock, reset, ctl.step && ctl.sep && ctl.newline,
      col_ff == '0, "column not restarted after newline")

endmodule

`default_nettype wire

// File: design/csv_decimal_field_parser_top.sv
// The input register, then the result register, lie between a separator byte
//   taken and its result; a separator waits there while a result is stalled.
// Throughput: one byte per cycle unless a separator waits on a stalled result.
// Reset (synchronous, active high) clears the field state, column and row
//   counters and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
// csv_decimal_field_parser_top
// Byte-stream CSV parser giving one fixed-point value per field.
// ----------------------------------------------------------------------------
`default_nettype none
`include "csv_decimal_field_parser_top_defines.svh"

module csv_decimal_field_parser_top #(
   parameter int INT_BITS    = cdfp_pkg::INT_BITS_DEF,
   parameter int FRAC_BITS   = cdfp_pkg::FRAC_BITS_DEF,
   parameter int MAX_COLUMNS = cdfp_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = cdfp_pkg::MAX_ROWS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cdfp_pkg::BYTE_W-1:0]   req_text_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cdfp_pkg::VALUE_W-1:0]       rsp_field_value,
   output logic [cdfp_pkg::COLUMN_W-1:0]      rsp_column_index,
   output logic [cdfp_pkg::ROW_W-1:0]         rsp_row_index,
   output logic                               rsp_row_end,
   output logic                               rsp_overflow
);
   import cdfp_pkg::*;

   logic                 byte_vld_ff, byte_vld_in;
   logic [BYTE_W-1:0]    byte_ff;
   logic                 byte_load;
   logic                 proc_stall;
   cdfp_dec_type         dec;
   cdfp_ctl_type         ctl;

   logic [VALUE_W-1:0]   acc_value;
   logic                 acc_ovf;
   logic [COLUMN_W-1:0]  pos_col;
   logic [ROW_W-1:0]     pos_row;

   logic                 rsp_vld_ff, rsp_vld_in;
   logic [VALUE_W-1:0]   value_ff;
   logic [COLUMN_W-1:0]  col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic                 row_end_ff;
   logic                 ovf_ff;
   logic                 emit;

   // Input register handshake
   assign dec        = cdfp_decode(byte_ff);
   assign proc_stall = dec.sep && rsp_vld_ff && rsp_stall;
   assign req_stall  = byte_vld_ff && proc_stall;
   assign byte_load  = req_valid && !req_stall;

   assign ctl.step    = byte_vld_ff && !proc_stall;
   assign ctl.sep     = dec.sep;
   assign ctl.newline = dec.newline;
   assign emit        = ctl.step && dec.sep;

   always_comb begin
      byte_vld_in = byte_vld_ff;
      if (byte_load) begin
         byte_vld_in = 1'b1;
      end else if (ctl.step) begin
         byte_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
      end else begin
         byte_vld_ff <= byte_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_load) begin
         byte_ff <= req_text_byte;
      end
   end

   cdfp_field_acc #(
      .INT_BITS  (INT_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_field_acc (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .dec         (dec),
      .field_value (acc_value),
      .overflow    (acc_ovf)
   );

   cdfp_pos_count #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_pos_count (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .column_index (pos_col),
      .row_index    (pos_row)
   );

   // Result register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (emit) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         value_ff   <= acc_value;
         col_ff     <= pos_col;
         row_ff     <= pos_row;
         row_end_ff <= dec.newline;
         ovf_ff     <= acc_ovf;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_field_value  = value_ff;
   assign rsp_column_index = col_ff;
   assign rsp_row_index    = row_ff;
   assign rsp_row_end      = row_end_ff;
   assign rsp_overflow     = ovf_ff;

   `CDFP_ASSERT_NEXT(a_emit_valid, clock, reset, emit, rsp_vld_ff,
      "separator consumed without a result")
   `CDFP_ASSERT_NEXT(a_no_spurious, clock, reset, !rsp_vld_ff && !emit, !rsp_vld_ff,
      "result appeared without a separator")
   `CDFP_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_vld_ff && rsp_stall, !emit,
      "pending result overwritten")

endmodule

`default_nettype wire
